[rtl/qmf_pkg.sv]
`default_nettype none
package qmf_pkg;

   localparam int TAPS         = 20;
   localparam int BEATS        = 5;
   localparam int TEMPLATE_LEN = 20;

   localparam int SAMPLE_W = 12;
   localparam int TIME_W   = 32;
   localparam int OUT_W    = 16;
   localparam int COEF_W   = 10;
   localparam int TAP_W    = $clog2(TAPS);

   localparam logic [OUT_W-1:0] THRESH_RESET = 16'd4750;
   localparam logic [OUT_W-1:0] SAT_MAX      = '1;

   // accumulator holds TAPS products of SAMPLE_W x COEF_W
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);

   // correlation scaling: drop the Q2.8 fraction, then divide by TAPS with a
   // reciprocal multiply; RECIP_SH keeps the product exact over the whole range
   localparam int     COEF_FRAC = 8;
   localparam int     SCALE_X_W = ACC_W - COEF_FRAC;
   localparam int     RECIP_SH  = SCALE_X_W + $clog2(TAPS);
   localparam longint RECIP_M   = ((longint'(1) << RECIP_SH) + longint'(TAPS) - 1)
                                  / longint'(TAPS);
   localparam int     RECIP_W   = $clog2(RECIP_M + 1);
   localparam int     SCALE_P_W = SCALE_X_W + RECIP_W;

   localparam longint RATE_NUM      = longint'(BEATS - 1) * 64'd600000000;
   localparam int     NUM_W         = $clog2(RATE_NUM + 1);
   localparam int     DIV_W         = NUM_W;
   localparam int     DVSR_W        = TIME_W;
   localparam int     DIV_CNT_W     = $clog2(DIV_W + 1);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   typedef logic [COEF_W-1:0] coef_type;
   typedef coef_type coef_table_type [TAPS];
   typedef coef_type template_type [TEMPLATE_LEN];

   localparam template_type QRS_TEMPLATE = '{
      10'd561, 10'd566, 10'd568, 10'd579, 10'd586, 10'd591, 10'd596, 10'd607, 10'd609, 10'd607,
      10'd591, 10'd576, 10'd556, 10'd532, 10'd520, 10'd509, 10'd504, 10'd502, 10'd497, 10'd497
   };

   // resample the template onto TAPS points; evaluated at elaboration
   function automatic coef_table_type build_coef_table();
      coef_table_type tbl;
      int k;
      for (int i = 0; i < TAPS; i++) begin
         k = (i * TEMPLATE_LEN) / TAPS;
         if (k >= TEMPLATE_LEN) k = TEMPLATE_LEN - 1;
         tbl[i] = QRS_TEMPLATE[k];
      end
      return tbl;
   endfunction

   localparam coef_table_type COEF_TABLE = build_coef_table();

   function automatic logic [OUT_W-1:0] sat16(input logic [DIV_W-1:0] q);
      if (|q[DIV_W-1:OUT_W]) return SAT_MAX;
      return q[OUT_W-1:0];
   endfunction

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_SCALE,
      S_DECIDE,
      S_RATE_WAIT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

[rtl/qmf_window.sv]
`default_nettype none
module qmf_window
   import qmf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                shift_en,
   input  wire logic [SAMPLE_W-1:0] sample_in,
   input  wire logic [TAP_W-1:0]    rd_idx,
   output logic      [SAMPLE_W-1:0] rd_sample,
   input  wire logic                reset
);

   logic [SAMPLE_W-1:0] win_ff [TAPS];
   logic [SAMPLE_W-1:0] win_in [TAPS];

   // index 0 oldest, TAPS-1 newest
   always_comb begin
      for (int i = 0; i < TAPS; i++) win_in[i] = win_ff[i];
      if (shift_en) begin
         for (int i = 0; i < TAPS - 1; i++) win_in[i] = win_ff[i+1];
         win_in[TAPS-1] = sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) win_ff[i] <= '0;
      end else begin
         for (int i = 0; i < TAPS; i++) win_ff[i] <= win_in[i];
      end
   end

   assign rd_sample = win_ff[rd_idx];

endmodule
`default_nettype wire

[rtl/qmf_div.sv]
`default_nettype none
module qmf_div
   import qmf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_ctrl_type      ctrl,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DVSR_W-1:0] divisor,
   output div_stat_type           stat,
   output logic      [DIV_W-1:0]  quotient
);

   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVSR_W-1:0]    dvsr_ff, dvsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVSR_W:0]      shifted;
   logic                 ge;

   // restoring division, one quotient bit per cycle; quo_ff shifts the
   // dividend out at the top and the quotient in at the bottom
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, dvsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DVSR_W'(shifted - {1'b0, dvsr_ff}) : shifted[DVSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

[rtl/qrs_matched_filter_beat_rate_top.sv]
// From input transfer: S_MAC accumulates TAPS products, then S_SCALE, S_DECIDE
// and, for a beat with nonzero span, S_RATE_WAIT on the divider; S_OUT then
// registers the result. One item at a time: the next transfer is taken in S_IDLE
// after the result is registered; a stalled result holds the next item in S_OUT.
// Reset (synchronous, active high) clears window, history, hysteresis flag and
// the output valid, and loads the threshold with 4750.
`default_nettype none
module qrs_matched_filter_beat_rate_top
   import qmf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire logic [TIME_W-1:0]     req_time_us,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [OUT_W-1:0]      rsp_correlation,
   output logic                       rsp_beat,
   output logic      [OUT_W-1:0]      rsp_rate_tenths_bpm,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   state_type state_ff, state_in;

   logic [TAP_W-1:0]    tap_ff, tap_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [OUT_W-1:0]    thresh_ff;
   logic                above_ff, above_in;
   logic [TIME_W-1:0]   hist_ff [BEATS];
   logic [TIME_W-1:0]   hist_in [BEATS];
   logic [OUT_W-1:0]    corr_ff, corr_in;
   logic                beat_ff, beat_in;
   logic [OUT_W-1:0]    rate_ff, rate_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_corr_ff, rsp_corr_in;
   logic                rsp_beat_ff, rsp_beat_in;
   logic [OUT_W-1:0]    rsp_rate_ff, rsp_rate_in;

   logic                accept;
   logic                shift_en;
   logic [SAMPLE_W-1:0] tap_sample;
   logic [PROD_W-1:0]   prod;
   logic [SCALE_X_W-1:0] scale_x;
   logic [SCALE_P_W-1:0] scale_prod;
   logic [TIME_W-1:0]   span;
   logic                csr_wr;

   div_ctrl_type        div_ctrl;
   div_stat_type        div_stat;
   logic [DIV_W-1:0]    div_dividend;
   logic [DVSR_W-1:0]   div_divisor;
   logic [DIV_W-1:0]    div_quotient;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign shift_en  = accept;

   qmf_window u_window (
      .clock     (clock),
      .shift_en  (shift_en),
      .sample_in (req_sample),
      .rd_idx    (tap_ff),
      .rd_sample (tap_sample),
      .reset     (reset)
   );

   qmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign prod = PROD_W'(tap_sample) * PROD_W'(COEF_TABLE[tap_ff]);
   // divide by 256 by dropping the fraction, then by TAPS via reciprocal
   assign scale_x    = acc_ff[ACC_W-1:COEF_FRAC];
   assign scale_prod = SCALE_P_W'(scale_x) * SCALE_P_W'(RECIP_M);
   // after the shift, history entry 1 becomes the oldest
   assign span = time_ff - hist_ff[1];

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      acc_in       = acc_ff;
      time_in      = time_ff;
      above_in     = above_ff;
      corr_in      = corr_ff;
      beat_in      = beat_ff;
      rate_in      = rate_ff;
      for (int i = 0; i < BEATS; i++) hist_in[i] = hist_ff[i];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_corr_in  = rsp_corr_ff;
      rsp_beat_in  = rsp_beat_ff;
      rsp_rate_in  = rsp_rate_ff;
      div_ctrl.start = 1'b0;
      div_dividend   = DIV_W'(RATE_NUM);
      div_divisor    = span;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               time_in  = req_time_us;
               tap_in   = '0;
               acc_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            acc_in = acc_ff + ACC_W'(prod);
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_W'(TAPS - 1)) begin
               tap_in   = '0;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            corr_in  = sat16(DIV_W'(scale_prod[SCALE_P_W-1:RECIP_SH]));
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            beat_in  = 1'b0;
            rate_in  = '0;
            state_in = S_OUT;
            if (above_ff && corr_ff < thresh_ff) begin
               above_in = 1'b0;
            end else if (!above_ff && corr_ff > thresh_ff) begin
               above_in = 1'b1;
               beat_in  = 1'b1;
               for (int i = 0; i < BEATS - 1; i++) hist_in[i] = hist_ff[i+1];
               hist_in[BEATS-1] = time_ff;
               if (span == '0) begin
                  rate_in = SAT_MAX;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in       = S_RATE_WAIT;
               end
            end
         end
         S_RATE_WAIT: begin
            if (div_stat.done) begin
               rate_in  = sat16(div_quotient);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = corr_ff;
               rsp_beat_in  = beat_ff;
               rsp_rate_in  = rate_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         above_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_ff       <= '0;
         for (int i = 0; i < BEATS; i++) hist_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         above_ff     <= above_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ff       <= tap_in;
         for (int i = 0; i < BEATS; i++) hist_ff[i] <= hist_in[i];
      end
      acc_ff      <= acc_in;
      time_ff     <= time_in;
      corr_ff     <= corr_in;
      beat_ff     <= beat_in;
      rate_ff     <= rate_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_beat_ff <= rsp_beat_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_correlation     = rsp_corr_ff;
   assign rsp_beat            = rsp_beat_ff;
   assign rsp_rate_tenths_bpm = rsp_rate_ff;

   // configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr && paddr[2] == CSR_IDX_THRESHOLD) begin
         thresh_ff <= pwdata[OUT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_THRESHOLD) ? CSR_DATA_W'(thresh_ff) : '0;

`ifndef SYNTHESIS
   a_rate_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_beat_ff |-> rsp_rate_ff == '0)
      else $error("rate nonzero on a result without a beat");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("input taken while an item is in progress");

   a_flag_rise_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(above_ff) |-> $past(state_ff == S_DECIDE))
      else $error("hysteresis flag set outside the decision step");
`endif

endmodule
`default_nettype wire

[dv/qrs_matched_filter_beat_rate_checker.sv]
`default_nettype none
module qrs_matched_filter_beat_rate_checker
   import qmf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire logic [TIME_W-1:0]     req_time_us,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [OUT_W-1:0]      rsp_correlation,
   input  wire logic                  rsp_beat,
   input  wire logic [OUT_W-1:0]      rsp_rate_tenths_bpm,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   input  wire logic                  pready,
   output int                         fail_count,
   output int                         pending,
   output int                         result_count,
   output int                         beat_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN  = 20;
   localparam int HIST = 5;
   localparam int unsigned CORR_SCALE = 256 * WIN;
   localparam longint unsigned RATE_SCALE = longint'(HIST - 1) * 64'd600000000;
   localparam logic [OUT_W-1:0] CEILING = 16'hFFFF;
   localparam logic [OUT_W-1:0] RESET_THRESHOLD = 16'd4750;
   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = {CSR_IDX_THRESHOLD, 2'b00};

   // Q2.8 template, tap 0 pairs with the oldest sample
   localparam bit [0:WIN-1][9:0] QRS_SHAPE = {
      10'd561, 10'd566, 10'd568, 10'd579, 10'd586, 10'd591, 10'd596, 10'd607, 10'd609, 10'd607,
      10'd591, 10'd576, 10'd556, 10'd532, 10'd520, 10'd509, 10'd504, 10'd502, 10'd497, 10'd497
   };

   typedef struct packed {
      logic [OUT_W-1:0] correlation;
      logic             beat;
      logic [OUT_W-1:0] rate_tenths_bpm;
   } detector_out_t;

   logic [SAMPLE_W-1:0] window_q [WIN];
   bit                  above_q;
   logic [TIME_W-1:0]   beat_log [HIST];
   logic [OUT_W-1:0]    threshold_q;
   detector_out_t       detector_outputs [$];
   int                  mismatches;
   int                  outputs_seen;
   int                  beats_seen;

   function automatic detector_out_t run_detector(input logic [SAMPLE_W-1:0] s,
                                                  input logic [TIME_W-1:0] t);
      detector_out_t   r;
      int unsigned     acc;
      int unsigned     scaled;
      logic [31:0]     span;
      longint unsigned bpm;
      r = '0;
      acc = 0;
      for (int i = 0; i < WIN - 1; i++) window_q[i] = window_q[i+1];
      window_q[WIN-1] = s;
      for (int i = 0; i < WIN; i++) acc += int'(window_q[i]) * int'(QRS_SHAPE[i]);
      scaled = acc / CORR_SCALE;
      r.correlation = (scaled > 65535) ? CEILING : scaled[OUT_W-1:0];
      // hysteresis: equality leaves the flag alone
      if (above_q && r.correlation < threshold_q) begin
         above_q = 1'b0;
      end else if (!above_q && r.correlation > threshold_q) begin
         above_q = 1'b1;
         r.beat = 1'b1;
         for (int i = 0; i < HIST - 1; i++) beat_log[i] = beat_log[i+1];
         beat_log[HIST-1] = t;
         span = beat_log[HIST-1] - beat_log[0];
         if (span == 0) begin
            r.rate_tenths_bpm = CEILING;
         end else begin
            bpm = RATE_SCALE / longint'(span);
            r.rate_tenths_bpm = (bpm > 65535) ? CEILING : bpm[OUT_W-1:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      detector_out_t head;
      if (reset) begin
         foreach (window_q[i]) window_q[i] = '0;
         foreach (beat_log[i]) beat_log[i] = '0;
         above_q = 1'b0;
         threshold_q = RESET_THRESHOLD;
         detector_outputs.delete();
      end else begin
         if (psel && penable && pready && paddr == THRESHOLD_ADDR) begin
            if (pwrite) begin
               threshold_q = pwdata[OUT_W-1:0];
            end else if (prdata !== {16'b0, threshold_q}) begin
               $error("beat_threshold: expected %0d, actual %0d", threshold_q, prdata);
               mismatches++;
            end
         end
         if (req_valid && !req_stall)
            detector_outputs.push_back(run_detector(req_sample, req_time_us));
         if (rsp_valid && !rsp_stall) begin
            outputs_seen++;
            if (rsp_beat === 1'b1) beats_seen++;
            if (detector_outputs.size() == 0) begin
               $error("result transfer with nothing pending: correlation %0d beat %0d rate %0d",
                      rsp_correlation, rsp_beat, rsp_rate_tenths_bpm);
               mismatches++;
            end else begin
               head = detector_outputs.pop_front();
               if (rsp_correlation !== head.correlation) begin
                  $error("correlation: expected %0d, actual %0d",
                         head.correlation, rsp_correlation);
                  mismatches++;
               end
               if (rsp_beat !== head.beat) begin
                  $error("beat: expected %0d, actual %0d", head.beat, rsp_beat);
                  mismatches++;
               end
               if (rsp_rate_tenths_bpm !== head.rate_tenths_bpm) begin
                  $error("rate_tenths_bpm: expected %0d, actual %0d",
                         head.rate_tenths_bpm, rsp_rate_tenths_bpm);
                  mismatches++;
               end
            end
         end
      end
      fail_count   <= mismatches;
      pending      <= detector_outputs.size();
      result_count <= outputs_seen;
      beat_count   <= beats_seen;
   end

endmodule
`default_nettype wire

[dv/tb_qrs_matched_filter_beat_rate_top.sv]
`default_nettype none
module tb_qrs_matched_filter_beat_rate_top;
   timeunit 1ns;
   timeprecision 1ps;
   import qmf_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 120;
   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = {CSR_IDX_THRESHOLD, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR     = {~CSR_IDX_THRESHOLD, 2'b00};
   localparam logic [SAMPLE_W-1:0]   FULL_SCALE     = '1;
   localparam logic [TIME_W-1:0]     LAST_STAMP     = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic [TIME_W-1:0]     req_time_us = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OUT_W-1:0]      rsp_correlation;
   logic                  rsp_beat;
   logic [OUT_W-1:0]      rsp_rate_tenths_bpm;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int result_count;
   int beat_count;

   int          samples_sent = 0;
   int          burst_left = 1;
   bit          sender_gaps = 1'b1;
   bit          hold_off_due = 1'b0;
   logic [31:0] stamp_us = '0;
   int          quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   qrs_matched_filter_beat_rate_top uut (
      .clock, .reset,
      .req_valid, .req_stall, .req_sample, .req_time_us,
      .rsp_valid, .rsp_stall, .rsp_correlation, .rsp_beat, .rsp_rate_tenths_bpm,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   qrs_matched_filter_beat_rate_checker detector_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_sample, .req_time_us,
      .rsp_valid, .rsp_stall, .rsp_correlation, .rsp_beat, .rsp_rate_tenths_bpm,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .fail_count, .pending, .result_count, .beat_count
   );

   // no transfer on any channel for too long means the block is hung
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stall modes, plus one long hold-off on request
   initial begin
      int stall_mode;
      int mode_left;
      int stall_tick;
      stall_mode = 0;
      mode_left = 0;
      stall_tick = 0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_due = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 75);
               default: rsp_stall <= (stall_tick % 3 != 0);
            endcase
         end
      end
   end

   task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
      int gap;
      req_valid <= 1'b1;
      req_sample <= s;
      req_time_us <= t;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gaps) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are junk; only the low half lands in the register
   task automatic set_threshold(input logic [OUT_W-1:0] level);
      logic [31:0] junk;
      junk = $urandom();
      csr_access(1'b1, THRESHOLD_ADDR, {junk[31:16], level});
      csr_access(1'b0, THRESHOLD_ADDR, '0);
   endtask

   // ECG-like stream: baseline, periodic QRS bursts, some noise samples;
   // timestamps step forward with occasional repeats and wild jumps
   task automatic play_rhythm(input int count, input int period_lo, input int period_hi,
                              input int step_lo, input int step_hi, input int noise_pct);
      int qrs_left;
      int beat_in;
      int roll;
      logic [SAMPLE_W-1:0] s;
      qrs_left = 0;
      beat_in = $urandom_range(period_lo, period_hi);
      repeat (count) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            s = SAMPLE_W'($urandom_range(0, 4095));
         end else if (qrs_left > 0) begin
            s = SAMPLE_W'($urandom_range(3000, 4095));
            qrs_left--;
         end else begin
            s = SAMPLE_W'($urandom_range(1500, 2000));
         end
         if (beat_in == 0) begin
            qrs_left = $urandom_range(5, 9);
            beat_in = $urandom_range(period_lo, period_hi);
         end else begin
            beat_in--;
         end
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            stamp_us = $urandom();
         end else if (roll >= 4) begin
            stamp_us = stamp_us + $urandom_range(step_lo, step_hi);
         end
         offer_sample(s, stamp_us);
      end
      drain_outputs();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // spare index must leave the threshold untouched
      csr_access(1'b1, SPARE_ADDR, $urandom());
      csr_access(1'b0, THRESHOLD_ADDR, '0);

      // equality while low: one full-scale sample lands exactly on the level
      set_threshold(16'd397);
      offer_sample(FULL_SCALE, '0);
      drain_outputs();
      // the same sample walks the window: rises with a zero-span beat,
      // sits on the level at the oldest tap, then falls away
      set_threshold(16'd448);
      repeat (20) offer_sample('0, '0);
      // early beat against reset zeros with the widest possible span
      offer_sample(FULL_SCALE, LAST_STAMP);
      offer_sample(FULL_SCALE, LAST_STAMP);
      drain_outputs();

      set_threshold(16'd4750);
      play_rhythm(200, 30, 60, 9000, 11000, 5);
      set_threshold(16'd0);
      play_rhythm(80, 30, 60, 9000, 11000, 10);
      set_threshold(16'hFFFF);
      play_rhythm(80, 30, 60, 0, 32'hFFFF_FFFF, 10);
      // short spans saturate the rate; the long output hold-off backs up the input
      set_threshold(16'($urandom_range(4400, 5500)));
      hold_off_due = 1'b1;
      play_rhythm(250, 25, 50, 0, 60, 4);
      set_threshold(16'd4750);
      sender_gaps = 1'b0;
      play_rhythm(250, 30, 60, 32'h0100_0000, 32'h8000_0000, 4);
      sender_gaps = 1'b1;
      set_threshold(16'($urandom_range(4200, 5800)));
      play_rhythm(290, 30, 70, 5000, 20000, 6);

      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d samples filtered, %0d results compared, %0d beats flagged",
               samples_sent, result_count, beat_count);
      $display("threshold at 0, 65535, reset level and mid-range; timestamp repeats and wraps");
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire
